// ===== src/fpcd_pkg.sv =====
`default_nettype none
package fpcd_pkg;

  localparam int unsigned SideW = 13;
  localparam logic [SideW-1:0] MaxSide = 13'd4096;
  localparam logic [SideW-1:0] SatMax = 13'd8191;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [1:0] {
    KIND_BYTE_RUN = 2'd0,
    KIND_BYTE_DELTA = 2'd1,
    KIND_WORD_DELTA = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_CHUNK_KIND = 2'd0,
    REG_FRAME_WIDTH = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_BR_LINE = 4'd1,
    PH_BR_OP = 4'd2,
    PH_BR_LIT = 4'd3,
    PH_BR_VAL = 4'd4,
    PH_LD_HDR = 4'd5,
    PH_LD_COUNT = 4'd6,
    PH_LD_SKIP = 4'd7,
    PH_LD_SIZE = 4'd8,
    PH_LD_LIT = 4'd9,
    PH_LD_REP = 4'd10,
    PH_WD_OP = 4'd11,
    PH_WD_SKIP = 4'd12,
    PH_WD_SIZE = 4'd13,
    PH_WD_LIT = 4'd14,
    PH_WD_PAIR = 4'd15
  } phase_e;

  // one parsed request; a zero length means no frame write
  typedef struct packed {
    logic [SideW-1:0] row;
    logic [SideW-1:0] col;
    logic [7:0]       len;
    logic [15:0]      val;
    logic             pair;
    logic             done;
  } desc_t;

endpackage
`default_nettype wire

// ===== src/fpcd_if.sv =====
`default_nettype none
interface fpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;
  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface fpcd_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [23:0] pixel_offset;
  logic [7:0]  run_length;
  logic [15:0] pixel_value;
  logic        pair_pattern;
  logic        chunk_done;
  logic        range_error;
  modport source (output valid, output write_valid, output pixel_offset, output run_length,
                  output pixel_value, output pair_pattern, output chunk_done,
                  output range_error, input ready);
  modport sink (input valid, input write_valid, input pixel_offset, input run_length,
                input pixel_value, input pair_pattern, input chunk_done,
                input range_error, output ready);
endinterface
`default_nettype wire

// ===== src/fpcd_front.sv =====
`default_nettype none
module fpcd_front
  import fpcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             start_i,
  input  wire logic [1:0]       kind_i,
  input  wire logic [SideW-1:0] w_eff_i,
  input  wire logic [SideW-1:0] h_eff_i,
  output      desc_t            desc_o
);

  phase_e      phase_q, phase_d;
  logic [12:0] row_q, row_d, col_q, col_d;
  logic [15:0] lines_q, lines_d;
  logic [13:0] pkts_q, pkts_d;
  logic [7:0]  run_q, run_d, held_q, held_d;
  logic        half_q, half_d;

  function automatic logic [12:0] sat13(input logic [16:0] v);
    return (v > {4'd0, SatMax}) ? SatMax : v[12:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      lines_q <= '0;
      pkts_q  <= '0;
      run_q   <= '0;
      held_q  <= '0;
      half_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      lines_q <= lines_d;
      pkts_q  <= pkts_d;
      run_q   <= run_d;
      held_q  <= held_d;
      half_q  <= half_d;
    end
  end

  always_comb begin
    phase_e      ph;
    logic [12:0] row_c, col_c;
    logic [7:0]  run_c;
    logic        pkt_end, line_end, br_adv, is_word;
    logic [15:0] wd;

    row_c = row_q; col_c = col_q; run_c = run_q; ph = phase_q;
    phase_d = phase_q; row_d = row_q; col_d = col_q; lines_d = lines_q;
    pkts_d = pkts_q; run_d = run_q; held_d = held_q; half_d = half_q;
    desc_o = '0;
    pkt_end = 1'b0; line_end = 1'b0; br_adv = 1'b0;
    wd = {byte_i, held_q};

    if (start_i) begin
      row_c = '0; col_c = '0; run_c = '0;
      row_d = '0; col_d = '0; lines_d = '0; pkts_d = '0; held_d = '0; half_d = 1'b0;
      wd = {byte_i, 8'd0};
      unique case (kind_i)
        KIND_BYTE_RUN: begin
          if (h_eff_i == '0) begin
            ph = PH_IDLE;
            desc_o.done = 1'b1;
          end else begin
            ph = PH_BR_LINE;
          end
        end
        KIND_BYTE_DELTA: begin ph = PH_LD_HDR; run_c = 8'd4; end
        KIND_WORD_DELTA: begin ph = PH_WD_OP; run_c = 8'd1; end
        default: begin ph = PH_IDLE; desc_o.done = 1'b1; end
      endcase
      phase_d = ph;
      run_d = run_c;
    end

    is_word = (ph == PH_WD_OP) || (ph == PH_WD_SKIP) || (ph == PH_WD_SIZE) ||
              (ph == PH_WD_LIT) || (ph == PH_WD_PAIR);

    unique case (ph)
      PH_BR_LINE: begin col_d = '0; br_adv = 1'b1; end
      PH_BR_OP: begin
        if (byte_i > 8'h7f) begin
          run_d = 8'(9'h100 - {1'b0, byte_i}); phase_d = PH_BR_LIT;
        end else begin
          run_d = byte_i; phase_d = PH_BR_VAL;
        end
      end
      PH_BR_LIT, PH_LD_LIT, PH_WD_LIT: begin
        desc_o.row = row_c; desc_o.col = col_c; desc_o.len = 8'd1;
        desc_o.val = {8'd0, byte_i};
        col_d = sat13({4'd0, col_c} + 17'd1);
        run_d = run_c - 8'd1;
        if (run_d == '0) begin
          if (ph == PH_BR_LIT) br_adv = 1'b1;
          else pkt_end = 1'b1;
        end
      end
      PH_BR_VAL, PH_LD_REP: begin
        desc_o.row = row_c; desc_o.col = col_c; desc_o.len = run_c;
        desc_o.val = {8'd0, byte_i};
        col_d = sat13({4'd0, col_c} + {9'd0, run_c});
        if (ph == PH_BR_VAL) br_adv = 1'b1;
        else pkt_end = 1'b1;
      end
      PH_LD_HDR: begin
        if (run_c == 8'd4 || run_c == 8'd2) begin
          held_d = byte_i;
        end else if (run_c == 8'd3) begin
          row_d = sat13({1'b0, wd});
        end else begin
          lines_d = wd;
          if (wd == '0) begin
            phase_d = PH_IDLE; desc_o.done = 1'b1;
          end else begin
            phase_d = PH_LD_COUNT;
          end
        end
        run_d = run_c - 8'd1;
      end
      PH_LD_COUNT: begin
        col_d = '0;
        pkts_d = {6'd0, byte_i};
        if (byte_i == '0) line_end = 1'b1;
        else phase_d = PH_LD_SKIP;
      end
      PH_LD_SKIP, PH_WD_SKIP: begin
        col_d = sat13({4'd0, col_c} + {9'd0, byte_i});
        phase_d = (ph == PH_LD_SKIP) ? PH_LD_SIZE : PH_WD_SIZE;
      end
      PH_LD_SIZE, PH_WD_SIZE: begin
        if (byte_i > 8'h7f) begin
          run_d = 8'(9'h100 - {1'b0, byte_i});
          half_d = 1'b0;
          phase_d = (ph == PH_LD_SIZE) ? PH_LD_REP : PH_WD_PAIR;
        end else if (byte_i == '0) begin
          pkt_end = 1'b1;
        end else if (ph == PH_LD_SIZE) begin
          run_d = byte_i; phase_d = PH_LD_LIT;
        end else begin
          run_d = {byte_i[6:0], 1'b0}; phase_d = PH_WD_LIT;
        end
      end
      PH_WD_OP: begin
        if (!half_d) begin
          held_d = byte_i; half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (run_c != '0) begin
            run_d = '0;
            lines_d = wd;
            if (wd == '0) begin phase_d = PH_IDLE; desc_o.done = 1'b1; end
          end else if (wd[15:14] == 2'b10) begin
            // last pixel of the current line
            desc_o.row = row_c; desc_o.col = w_eff_i - 13'd1; desc_o.len = 8'd1;
            desc_o.val = {8'd0, wd[7:0]};
          end else if (wd[15:14] == 2'b11) begin
            row_d = sat13({4'd0, row_c} + (17'h10000 - {1'b0, wd}));
          end else if (!wd[14]) begin
            col_d = '0;
            pkts_d = wd[13:0];
            if (wd[13:0] == '0) line_end = 1'b1;
            else phase_d = PH_WD_SKIP;
          end
        end
      end
      PH_WD_PAIR: begin
        if (!half_q) begin
          held_d = byte_i; half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          desc_o.row = row_c; desc_o.col = col_c; desc_o.len = run_c;
          desc_o.val = wd; desc_o.pair = 1'b1;
          col_d = sat13({4'd0, col_c} + {8'd0, run_c, 1'b0});
          pkt_end = 1'b1;
        end
      end
      default: ;
    endcase

    if (pkt_end) begin
      pkts_d = pkts_q - 14'd1;
      if (pkts_d == '0) line_end = 1'b1;
      else phase_d = is_word ? PH_WD_SKIP : PH_LD_SKIP;
    end
    if (line_end) begin
      row_d = sat13({4'd0, row_d} + 17'd1);
      lines_d = lines_q - 16'd1;
      if (lines_d == '0) begin
        phase_d = PH_IDLE; desc_o.done = 1'b1;
      end else begin
        phase_d = is_word ? PH_WD_OP : PH_LD_COUNT;
        half_d = 1'b0;
      end
    end
    if (br_adv) begin
      if (col_d >= w_eff_i) begin
        row_d = sat13({4'd0, row_c} + 17'd1);
        if (row_d >= h_eff_i) begin
          phase_d = PH_IDLE; desc_o.done = 1'b1;
        end else begin
          phase_d = PH_BR_LINE;
        end
      end else begin
        phase_d = PH_BR_OP;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/fpcd_queue.sv =====
`default_nettype none
module fpcd_queue
  import fpcd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t wdata_i,
  output      logic  full_o,
  input  wire logic  pop_i,
  output      logic  valid_o,
  output      desc_t rdata_o
);

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i) rd_q <= rd_q + QPtrW'(1);
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && !pop_i) |=> $stable(cnt_q)) else $error("queue count drifted");

endmodule
`default_nettype wire

// ===== src/fpcd_back.sv =====
`default_nettype none
module fpcd_back
  import fpcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire desc_t            q_data_i,
  output      logic             q_pop_o,
  input  wire logic [SideW-1:0] w_eff_i,
  input  wire logic [SideW-1:0] h_eff_i,
  fpcd_out_if.source            out_o
);

  logic        s1_vld_q, o_vld_q;
  logic        s1_wr_q, s1_err_q;
  logic [25:0] s1_prod_q;
  desc_t       s1_q;
  logic        adv_out, s1_take;
  logic [8:0]  span;
  logic [13:0] end_col;
  logic        in_frame;
  logic [23:0] off;

  logic        wv_q, err_q, pair_q, done_q;
  logic [23:0] off_q;
  logic [7:0]  len_q;
  logic [15:0] val_q;

  assign adv_out = !o_vld_q || out_o.ready;
  assign s1_take = !s1_vld_q || adv_out;
  assign q_pop_o = q_valid_i && s1_take;

  assign span     = q_data_i.pair ? {q_data_i.len, 1'b0} : {1'b0, q_data_i.len};
  assign end_col  = {1'b0, q_data_i.col} + {5'd0, span};
  assign in_frame = (q_data_i.row < h_eff_i) && (end_col <= {1'b0, w_eff_i});
  assign off      = s1_prod_q[23:0] + {11'd0, s1_q.col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (s1_take) s1_vld_q <= q_pop_o;
      if (adv_out) o_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_q      <= q_data_i;
      s1_prod_q <= q_data_i.row * w_eff_i;
      s1_wr_q   <= (q_data_i.len != '0) && in_frame;
      s1_err_q  <= (q_data_i.len != '0) && !in_frame;
    end
    if (adv_out) begin
      wv_q   <= s1_wr_q;
      err_q  <= s1_err_q;
      done_q <= s1_q.done;
      off_q  <= s1_wr_q ? off : '0;
      len_q  <= s1_wr_q ? s1_q.len : '0;
      val_q  <= s1_wr_q ? s1_q.val : '0;
      pair_q <= s1_wr_q && s1_q.pair;
    end
  end

  assign out_o.valid        = o_vld_q;
  assign out_o.write_valid  = wv_q;
  assign out_o.pixel_offset = off_q;
  assign out_o.run_length   = len_q;
  assign out_o.pixel_value  = val_q;
  assign out_o.pair_pattern = pair_q;
  assign out_o.chunk_done   = done_q;
  assign out_o.range_error  = err_q;

  a_write_or_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> !(wv_q && err_q)) else $error("write and range error together");
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !wv_q) |-> (off_q == '0 && len_q == '0 && val_q == '0 && !pair_q))
    else $error("fields set without a write");
  a_write_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && wv_q) |-> (len_q != '0)) else $error("write with zero length");

endmodule
`default_nettype wire

// ===== src/flic_pixel_chunk_decoder.sv =====
// FLIC pixel chunk decoder.
// in_i takes one payload byte per request; chunk_start marks the first byte of a chunk
// and restarts the parser with the chunk kind held in the config register. Every byte
// yields exactly one result on out_o: an optional frame write (offset, run length, pixel
// or pixel pair), chunk_done on the byte that ends the chunk, and range_error for a
// write that fell outside the frame.
// Config registers (chunk kind, frame width, frame height) are written through
// cfg_we_i / cfg_index_i / cfg_data_i while no chunk byte is in flight.
// Throughput: one byte per cycle while the queue is not full. The parser decodes each byte
// combinationally and pushes a request into a four-entry queue; the back end multiplies
// row by width in one stage and adds the column in the next, which feeds the output
// register that drives out_o.
// When out_o stalls, results hold in the output register, the back end holds, and the
// queue fills; in_i.ready drops only when the queue is full.
// Reset clears the parser to idle, empties the queue, and loads kind 0, width 320 and
// height 200. Bytes before any chunk start, or after a chunk is done, give all-zero results.
`default_nettype none
module flic_pixel_chunk_decoder
  import fpcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [SideW-1:0] cfg_data_i,
  fpcd_in_if.sink               in_i,
  fpcd_out_if.source            out_o
);

  logic [1:0]       kind_q;
  logic [SideW-1:0] width_q, height_q, w_eff, h_eff;
  logic             q_full, q_valid, q_pop, take;
  desc_t            desc, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_BYTE_RUN;
      width_q  <= 13'd320;
      height_q <= 13'd200;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_CHUNK_KIND:   kind_q <= cfg_data_i[1:0];
        REG_FRAME_WIDTH:  width_q <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q > MaxSide) ? MaxSide : width_q;
  assign h_eff = (height_q > MaxSide) ? MaxSide : height_q;

  assign in_i.ready = !q_full;
  assign take = in_i.valid && !q_full;

  fpcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (in_i.data_byte),
    .start_i (in_i.chunk_start),
    .kind_i  (kind_q),
    .w_eff_i (w_eff),
    .h_eff_i (h_eff),
    .desc_o  (desc)
  );

  fpcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .wdata_i (desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  fpcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .w_eff_i   (w_eff),
    .h_eff_i   (h_eff),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  import fpcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        wv;
    logic [23:0] off;
    logic [7:0]  len;
    logic [15:0] val;
    logic        pair;
    logic        done;
    logic        err;
  } frame_write_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = REG_NONE;
  logic [SideW-1:0] cfg_data_i = '0;

  fpcd_in_if  in_if ();
  fpcd_out_if out_if ();

  flic_pixel_chunk_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  frame_write_t expected_writes[$];
  int           n_errors = 0;
  bit           idling_on = 1'b1;
  bit           long_hold_req = 1'b0;
  logic [7:0]   chunk_bytes[$];
  int           bytes_sent = 0;

  // decoder state kept by the bench
  kind_e        cur_kind = KIND_BYTE_RUN;
  int unsigned  cur_w = 320, cur_h = 200;
  phase_e       ph = PH_IDLE;
  int unsigned  row_q, col_q, lines_q, pkts_q, run_q, held_q, half_q;
  frame_write_t pr;

  function automatic int unsigned sat13(int unsigned v);
    return (v > 8191) ? 8191 : v;
  endfunction
  function automatic int unsigned eff_w();
    return (cur_w > 4096) ? 4096 : cur_w;
  endfunction
  function automatic int unsigned eff_h();
    return (cur_h > 4096) ? 4096 : cur_h;
  endfunction

  function automatic void emit_write(int unsigned y, int unsigned x, int unsigned len,
                                     int unsigned v, bit pair);
    int unsigned span;
    span = pair ? 2 * len : len;
    if (len == 0) return;
    if (y < eff_h() && x + span <= eff_w()) begin
      pr.wv = 1'b1;
      pr.off = 24'(y * eff_w() + x);
      pr.len = 8'(len);
      pr.val = 16'(v);
      pr.pair = pair;
    end else begin
      pr.err = 1'b1;
    end
  endfunction

  function automatic void end_chunk();
    ph = PH_IDLE;
    pr.done = 1'b1;
  endfunction

  function automatic void br_advance();
    if (col_q >= eff_w()) begin
      row_q = sat13(row_q + 1);
      if (row_q >= eff_h()) end_chunk();
      else ph = PH_BR_LINE;
    end else begin
      ph = PH_BR_OP;
    end
  endfunction

  function automatic void line_end(bit word);
    row_q = sat13(row_q + 1);
    lines_q = (lines_q - 1) & 16'hffff;
    if (lines_q == 0) end_chunk();
    else begin
      ph = word ? PH_WD_OP : PH_LD_COUNT;
      half_q = 0;
    end
  endfunction

  function automatic void packet_end(bit word);
    pkts_q = (pkts_q - 1) & 14'h3fff;
    if (pkts_q == 0) line_end(word);
    else ph = word ? PH_WD_SKIP : PH_LD_SKIP;
  endfunction

  function automatic void word_op(int unsigned op);
    if ((op & 16'hc000) == 16'h8000) begin
      if (eff_w() == 0) pr.err = 1'b1;
      else emit_write(row_q, eff_w() - 1, 1, op & 8'hff, 1'b0);
    end else if ((op & 16'hc000) == 16'hc000) begin
      row_q = sat13(row_q + (32'h10000 - op));
    end else if ((op & 16'h4000) == 0) begin
      col_q = 0;
      pkts_q = op & 16'h3fff;
      if (pkts_q == 0) line_end(1'b1);
      else ph = PH_WD_SKIP;
    end
  endfunction

  function automatic frame_write_t decode_byte(logic [7:0] din, logic st);
    int unsigned b, w;
    b = din;
    pr = '0;
    if (st) begin
      row_q = 0; col_q = 0; lines_q = 0; pkts_q = 0; run_q = 0; held_q = 0; half_q = 0;
      case (cur_kind)
        KIND_BYTE_RUN: begin
          if (eff_h() == 0) begin
            end_chunk();
            return pr;
          end
          ph = PH_BR_LINE;
        end
        KIND_BYTE_DELTA: begin ph = PH_LD_HDR; run_q = 4; end
        KIND_WORD_DELTA: begin ph = PH_WD_OP; run_q = 1; end
        default: begin
          end_chunk();
          return pr;
        end
      endcase
    end
    case (ph)
      PH_BR_LINE: begin col_q = 0; br_advance(); end
      PH_BR_OP: begin
        if (b > 8'h7f) begin run_q = 256 - b; ph = PH_BR_LIT; end
        else begin run_q = b; ph = PH_BR_VAL; end
      end
      PH_BR_LIT: begin
        emit_write(row_q, col_q, 1, b, 1'b0);
        col_q = sat13(col_q + 1);
        run_q = (run_q - 1) & 8'hff;
        if (run_q == 0) br_advance();
      end
      PH_BR_VAL: begin
        emit_write(row_q, col_q, run_q, b, 1'b0);
        col_q = sat13(col_q + run_q);
        br_advance();
      end
      PH_LD_HDR: begin
        if (run_q == 4 || run_q == 2) held_q = b;
        else if (run_q == 3) row_q = sat13(held_q | (b << 8));
        else begin
          lines_q = held_q | (b << 8);
          if (lines_q == 0) end_chunk();
          else ph = PH_LD_COUNT;
        end
        run_q = (run_q - 1) & 8'hff;
      end
      PH_LD_COUNT: begin
        col_q = 0;
        pkts_q = b;
        if (b == 0) line_end(1'b0);
        else ph = PH_LD_SKIP;
      end
      PH_LD_SKIP, PH_WD_SKIP: begin
        col_q = sat13(col_q + b);
        ph = (ph == PH_LD_SKIP) ? PH_LD_SIZE : PH_WD_SIZE;
      end
      PH_LD_SIZE: begin
        if (b > 8'h7f) begin run_q = 256 - b; ph = PH_LD_REP; end
        else if (b == 0) packet_end(1'b0);
        else begin run_q = b; ph = PH_LD_LIT; end
      end
      PH_LD_LIT, PH_WD_LIT: begin
        emit_write(row_q, col_q, 1, b, 1'b0);
        col_q = sat13(col_q + 1);
        run_q = (run_q - 1) & 8'hff;
        if (run_q == 0) packet_end(ph == PH_WD_LIT);
      end
      PH_LD_REP: begin
        emit_write(row_q, col_q, run_q, b, 1'b0);
        col_q = sat13(col_q + run_q);
        packet_end(1'b0);
      end
      PH_WD_OP: begin
        if (half_q == 0) begin
          held_q = b;
          half_q = 1;
        end else begin
          half_q = 0;
          w = held_q | (b << 8);
          if (run_q != 0) begin
            run_q = 0;
            lines_q = w;
            if (lines_q == 0) end_chunk();
          end else begin
            word_op(w);
          end
        end
      end
      PH_WD_SIZE: begin
        if (b > 8'h7f) begin run_q = 256 - b; half_q = 0; ph = PH_WD_PAIR; end
        else if (b == 0) packet_end(1'b1);
        else begin run_q = 2 * b; ph = PH_WD_LIT; end
      end
      PH_WD_PAIR: begin
        if (half_q == 0) begin
          held_q = b;
          half_q = 1;
        end else begin
          half_q = 0;
          emit_write(row_q, col_q, run_q, held_q | (b << 8), 1'b1);
          col_q = sat13(col_q + 2 * run_q);
          packet_end(1'b1);
        end
      end
      default: ;
    endcase
    return pr;
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // send one payload byte, predicting its result on acceptance
  task automatic send_byte(logic [7:0] b, logic st);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.chunk_start = st;
    do @(posedge clk_i); while (!in_if.ready);
    expected_writes.push_back(decode_byte(b, st));
    bytes_sent++;
  endtask

  task automatic send_chunk();
    foreach (chunk_bytes[i]) send_byte(chunk_bytes[i], i == 0);
    chunk_bytes.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = SideW'(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_index_i = REG_NONE;
    case (idx)
      REG_CHUNK_KIND: cur_kind = kind_e'(v & 3);
      REG_FRAME_WIDTH: cur_w = v & 13'h1fff;
      REG_FRAME_HEIGHT: cur_h = v & 13'h1fff;
      default: ;
    endcase
  endtask

  task automatic set_frame(kind_e k, int unsigned w, int unsigned h);
    wait_drained();
    write_reg(REG_CHUNK_KIND, k);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic void push16(int unsigned v);
    chunk_bytes.push_back(8'(v));
    chunk_bytes.push_back(8'(v >> 8));
  endfunction

  function automatic void build_byte_run(int unsigned w, int unsigned h);
    int unsigned col, n;
    for (int unsigned y = 0; y < h; y++) begin
      chunk_bytes.push_back(8'($urandom));
      col = 0;
      while (col < w) begin
        n = (w - col > 8) ? $urandom_range(1, 8) : $urandom_range(1, w - col);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 12);  // overshoot or empty
        if ($urandom_range(0, 1) == 0 && n > 0) begin
          chunk_bytes.push_back(8'(256 - n));
          repeat (n) chunk_bytes.push_back(8'($urandom));
        end else begin
          chunk_bytes.push_back(8'(n));
          chunk_bytes.push_back(8'($urandom));
        end
        col += (n == 0) ? 1 : n;
        if (n == 0 && $urandom_range(0, 1) == 0) break;
      end
    end
  endfunction

  function automatic void build_byte_delta(int unsigned h);
    int unsigned lines, pk, n;
    lines = $urandom_range(0, 4);
    push16($urandom_range(0, 9) == 0 ? $urandom_range(0, 16'hffff) : $urandom_range(0, h));
    push16(lines);
    repeat (lines) begin
      pk = $urandom_range(0, 3);
      chunk_bytes.push_back(8'(pk));
      repeat (pk) begin
        chunk_bytes.push_back(8'($urandom_range(0, 7)));
        case ($urandom_range(0, 4))
          0: chunk_bytes.push_back(8'h00);
          1, 2: begin
            n = $urandom_range(1, 5);
            chunk_bytes.push_back(8'(n));
            repeat (n) chunk_bytes.push_back(8'($urandom));
          end
          default: begin
            chunk_bytes.push_back(8'(256 - $urandom_range(1, 128)));
            chunk_bytes.push_back(8'($urandom));
          end
        endcase
      end
    end
  endfunction

  function automatic void build_word_delta();
    int unsigned lines, pk, n;
    lines = $urandom_range(0, 4);
    push16(lines);
    repeat (lines) begin
      if ($urandom_range(0, 3) == 0) push16(32'h10000 - $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) push16(16'h8000 | $urandom_range(0, 16'h3fff));
      if ($urandom_range(0, 4) == 0) push16(16'h4000 | $urandom_range(0, 16'h3fff));
      pk = $urandom_range(0, 3);
      push16(pk);
      repeat (pk) begin
        chunk_bytes.push_back(8'($urandom_range(0, 7)));
        case ($urandom_range(0, 4))
          0: chunk_bytes.push_back(8'h00);
          1, 2: begin
            n = $urandom_range(1, 3);
            chunk_bytes.push_back(8'(n));
            repeat (2 * n) chunk_bytes.push_back(8'($urandom));
          end
          default: begin
            chunk_bytes.push_back(8'(256 - $urandom_range(1, 128)));
            push16($urandom_range(0, 16'hffff));
          end
        endcase
      end
    end
  endfunction

  // one chunk of random kind and small size; a few use the largest frame
  task automatic random_chunk();
    int unsigned w, h, k, sel;
    sel = $urandom_range(0, 19);
    k = $urandom_range(0, 2);
    w = $urandom_range(1, 24);
    h = $urandom_range(1, 6);
    if (sel == 0) begin w = 4096; h = (k == 0) ? 1 : 4096; end
    else if (sel == 1) begin w = 1; h = 1; end
    if (sel < 3 || k != cur_kind || $urandom_range(0, 3) == 0) set_frame(kind_e'(k), w, h);
    if ($urandom_range(0, 14) == 0) begin
      // noise: random bytes under a start
      chunk_bytes.push_back(8'($urandom));
      repeat ($urandom_range(1, 12)) chunk_bytes.push_back(8'($urandom));
    end else begin
      case (cur_kind)
        KIND_BYTE_RUN: build_byte_run(eff_w(), eff_h());
        KIND_BYTE_DELTA: build_byte_delta(eff_h());
        default: build_word_delta();
      endcase
      // cut the chunk short now and then
      if ($urandom_range(0, 9) == 0 && chunk_bytes.size() > 2)
        chunk_bytes = chunk_bytes[0:$urandom_range(1, chunk_bytes.size() - 1)];
      // keep a line of a wide frame to a short prefix
      if (chunk_bytes.size() > 160) chunk_bytes = chunk_bytes[0:159];
      repeat ($urandom_range(0, 2)) chunk_bytes.push_back(8'($urandom));
    end
    send_chunk();
  endtask

  task automatic test_idle_and_unknown();
    send_byte(8'h5a, 1'b0);
    set_frame(KIND_UNKNOWN, 320, 200);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_extremes();
    // last row of the largest frame: a repeat run, then a one-byte literal
    set_frame(KIND_BYTE_DELTA, 4096, 4096);
    chunk_bytes = '{8'hff, 8'h0f, 8'h01, 8'h00, 8'h02, 8'hfa, 8'h80, 8'hff, 8'hff, 8'h01,
                    8'h00};
    send_chunk();
    // header says no lines
    set_frame(KIND_WORD_DELTA, 1, 1);
    chunk_bytes = '{8'h00, 8'h00};
    send_chunk();
    // line skip, last pixel, ignored opcode, odd skip, pair run
    set_frame(KIND_WORD_DELTA, 16, 4);
    chunk_bytes = '{8'h01, 8'h00, 8'hff, 8'hff, 8'h55, 8'h80, 8'h01, 8'h40, 8'h01, 8'h00,
                    8'h03, 8'hfe, 8'haa, 8'hbb};
    send_chunk();
  endtask

  task automatic test_random();
    while (bytes_sent < 1000) random_chunk();
  endtask

  task automatic test_backpressure();
    set_frame(KIND_BYTE_RUN, 24, 4);
    long_hold_req = 1'b1;
    build_byte_run(24, 4);
    send_chunk();
  endtask

  task automatic test_no_idling();
    wait_drained();
    idling_on = 1'b0;
    while (bytes_sent < 1250) random_chunk();
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        if (idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 7);
        if (stall_left > 0) stall_left--;
        out_if.ready = (stall_left == 0) && rst_ni;
      end
    end
  end

  always @(posedge clk_i) begin
    frame_write_t got, want;
    if (out_if.valid && out_if.ready) begin
      got = '{out_if.write_valid, out_if.pixel_offset, out_if.run_length, out_if.pixel_value,
              out_if.pair_pattern, out_if.chunk_done, out_if.range_error};
      if (expected_writes.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_writes.pop_front();
        if (got.wv !== want.wv)
          report_mismatch($sformatf("write_valid %0d exp %0d", got.wv, want.wv));
        if (got.off !== want.off)
          report_mismatch($sformatf("pixel_offset %0d exp %0d", got.off, want.off));
        if (got.len !== want.len)
          report_mismatch($sformatf("run_length %0d exp %0d", got.len, want.len));
        if (got.val !== want.val)
          report_mismatch($sformatf("pixel_value %h exp %h", got.val, want.val));
        if (got.pair !== want.pair)
          report_mismatch($sformatf("pair_pattern %0d exp %0d", got.pair, want.pair));
        if (got.done !== want.done)
          report_mismatch($sformatf("chunk_done %0d exp %0d", got.done, want.done));
        if (got.err !== want.err)
          report_mismatch($sformatf("range_error %0d exp %0d", got.err, want.err));
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i ||
          expected_writes.size() == 0)
        quiet = 0;
      else
        quiet++;
      if (quiet >= 2000) begin
        $display("FAIL flic_pixel_chunk_decoder");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.chunk_start = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_and_unknown();
    test_extremes();
    test_backpressure();
    test_random();
    test_no_idling();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) $display("PASS flic_pixel_chunk_decoder");
    else $display("FAIL flic_pixel_chunk_decoder");
    $finish;
  end

endmodule
`default_nettype wire
